// ----- rtl/core/pcoc_pkg.sv -----
// ----------------------------------------------------------------------------
// pcoc_pkg
// Shared widths and types for the phase current offset calibrator.
// ----------------------------------------------------------------------------
package pcoc_pkg;

  localparam int IN_W     = 12;
  localparam int OUT_W    = 36;
  localparam int GAIN_W   = 24;
  localparam int PHASES   = 3;

  typedef logic [IN_W-1:0]   sample_t;
  typedef logic [OUT_W-1:0]  current_t;
  typedef logic [GAIN_W-1:0] gain_t;

  // control from the sequencer to each lane
  typedef struct packed {
    logic acc;   // calibrating word accepted: accumulate
    logic fin;   // word that completes the count: load rounding numerator
    logic step;  // offset load from the numerator
    logic done;  // offsets valid for the word now accepted
  } pcoc_ctrl_t;

  // merged result word
  typedef struct packed {
    current_t current_u;
    current_t current_v;
    current_t current_w;
    logic     calibrated;
  } pcoc_word_t;

endpackage

// ----- rtl/core/pcoc_if.sv -----
// ----------------------------------------------------------------------------
// pcoc_if
// Valid/ready channels for the sample and current words.
// ----------------------------------------------------------------------------
interface pcoc_in_if;
  logic              valid;
  logic              ready;
  pcoc_pkg::sample_t sample_u;
  pcoc_pkg::sample_t sample_v;
  pcoc_pkg::sample_t sample_w;

  modport source (output valid, output sample_u, output sample_v, output sample_w,
                  input ready);
  modport sink   (input valid, input sample_u, input sample_v, input sample_w,
                  output ready);
endinterface

interface pcoc_out_if;
  logic               valid;
  logic               ready;
  pcoc_pkg::current_t current_u;
  pcoc_pkg::current_t current_v;
  pcoc_pkg::current_t current_w;
  logic               calibrated;

  modport source (output valid, output current_u, output current_v, output current_w,
                  output calibrated, input ready);
  modport sink   (input valid, input current_u, input current_v, input current_w,
                  input calibrated, output ready);
endinterface

// ----- rtl/core/phase_current_offset_calibrator.sv -----
// ----------------------------------------------------------------------------
// phase_current_offset_calibrator
// Zero-offset calibration and scaling of three phase current samples.
// ----------------------------------------------------------------------------
// in_ch carries one word of three raw ADC samples (U, V, W); out_ch returns
// one word per input: three Q.16 currents and the calibrated flag.
// cfg_we/cfg_wdata write gain_r (unsigned Q8.16), taking effect on the
// next word; it never restarts calibration.
// After reset the first CAL_SAMPLES words are summed per phase and answered
// with zero currents; the word completing the count carries calibrated = 1.
// In the cycle after that word each lane forms its rounded mean by a
// constant reciprocal multiply; in_ch.ready is low for that one cycle, once
// per reset.
// Otherwise one word per cycle while out_ch takes them; results are
// registered. The output register has a skid stage, so a second word is
// taken while the receiver stalls; in_ch.ready drops once both are full.
// Reset is synchronous, active low, and clears sums, offsets, gain and flags.
// ----------------------------------------------------------------------------
module phase_current_offset_calibrator #(
  parameter int CAL_SAMPLES = 100,
  parameter int SAMPLE_BITS = 12
) (
  input  logic              clk,
  input  logic              rst_n,
  pcoc_in_if.sink           in_ch,
  pcoc_out_if.source        out_ch,
  input  logic              cfg_we,
  input  pcoc_pkg::gain_t   cfg_wdata
);

  pcoc_pkg::gain_t      gain_r;
  pcoc_pkg::pcoc_ctrl_t ctl;
  pcoc_pkg::current_t   lane_cur [pcoc_pkg::PHASES];
  pcoc_pkg::sample_t    lane_smp [pcoc_pkg::PHASES];
  logic                 merge_ready, in_ready, accept, calibrated;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r <= '0;
    end else if (cfg_we) begin
      gain_r <= cfg_wdata;
    end
  end

  assign in_ch.ready = in_ready;
  assign lane_smp[0] = in_ch.sample_u;
  assign lane_smp[1] = in_ch.sample_v;
  assign lane_smp[2] = in_ch.sample_w;

  pcoc_ctrl #(
    .CAL_SAMPLES (CAL_SAMPLES)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_ch.valid),
    .merge_ready (merge_ready),
    .in_ready    (in_ready),
    .accept      (accept),
    .calibrated  (calibrated),
    .ctl         (ctl)
  );

  for (genvar p = 0; p < pcoc_pkg::PHASES; p++) begin : g_lane
    pcoc_lane #(
      .CAL_SAMPLES (CAL_SAMPLES),
      .SAMPLE_BITS (SAMPLE_BITS)
    ) u_lane (
      .clk     (clk),
      .rst_n   (rst_n),
      .ctl     (ctl),
      .sample  (lane_smp[p]),
      .gain    (gain_r),
      .current (lane_cur[p])
    );
  end

  pcoc_merge u_merge (
    .clk        (clk),
    .rst_n      (rst_n),
    .up_valid   (accept),
    .up_ready   (merge_ready),
    .lane_cur   (lane_cur),
    .calibrated (calibrated),
    .dn         (out_ch)
  );

endmodule

// ----- rtl/core/pcoc_ctrl.sv -----
// ----------------------------------------------------------------------------
// pcoc_ctrl
// Calibration sequencer: sample count, calibrated flag and offset load.
// ----------------------------------------------------------------------------
module pcoc_ctrl #(
  parameter int CAL_SAMPLES = 100
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                merge_ready,
  output logic                in_ready,
  output logic                accept,
  output logic                calibrated,
  output pcoc_pkg::pcoc_ctrl_t ctl
);

  localparam int CW    = $clog2(CAL_SAMPLES + 1);

  logic [CW-1:0] count_r, count_nxt;
  logic          done_r, done_nxt;
  logic          busy_r, busy_nxt;
  logic          last;

  assign in_ready   = merge_ready && !busy_r;
  assign accept     = in_valid && in_ready;
  assign last       = (count_r + CW'(1)) == CW'(CAL_SAMPLES);
  assign calibrated = done_r || ctl.fin;

  always_comb begin
    ctl.acc  = accept && !done_r;
    ctl.fin  = accept && !done_r && last;
    ctl.step = busy_r;
    ctl.done = done_r;
  end

  always_comb begin
    count_nxt = count_r;
    done_nxt  = done_r;
    busy_nxt  = 1'b0;
    if (ctl.acc) begin
      count_nxt = count_r + CW'(1);
    end
    if (ctl.fin) begin
      done_nxt = 1'b1;
      busy_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      done_r  <= 1'b0;
      busy_r  <= 1'b0;
    end else begin
      count_r <= count_nxt;
      done_r  <= done_nxt;
      busy_r  <= busy_nxt;
    end
  end

  a_busy_done: assert property (@(posedge clk) disable iff (!rst_n) busy_r |-> done_r)
    else $error("offset load before calibration complete");
  a_busy_block: assert property (@(posedge clk) disable iff (!rst_n) busy_r |-> !accept)
    else $error("word accepted while offsets are being loaded");
  a_fin_busy: assert property (@(posedge clk) disable iff (!rst_n) ctl.fin |=> busy_r)
    else $error("offset load not started on completing word");
  a_busy_once: assert property (@(posedge clk) disable iff (!rst_n) busy_r |=> !busy_r)
    else $error("offset load longer than one cycle");
  a_done_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(done_r) |-> $past(accept))
    else $error("calibrated without an accepted word");

endmodule

// ----- rtl/core/pcoc_lane.sv -----
// ----------------------------------------------------------------------------
// pcoc_lane
// One phase: sample accumulator, rounded mean offset and scaled current.
// ----------------------------------------------------------------------------
module pcoc_lane #(
  parameter int CAL_SAMPLES = 100,
  parameter int SAMPLE_BITS = 12
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  pcoc_pkg::pcoc_ctrl_t ctl,
  input  pcoc_pkg::sample_t    sample,
  input  pcoc_pkg::gain_t      gain,
  output pcoc_pkg::current_t   current
);

  localparam int UB    = (SAMPLE_BITS < pcoc_pkg::IN_W) ? SAMPLE_BITS : pcoc_pkg::IN_W;
  localparam int SUM_W = UB + $clog2(CAL_SAMPLES + 1);
  localparam int XW    = SUM_W + 1;
  localparam int DW    = $clog2(2 * CAL_SAMPLES + 1);
  localparam int K     = XW + DW;
  // ceil(2^K / 2N): the product shifted down by K is the exact quotient
  localparam longint unsigned RECIP_V =
    ((64'd1 << K) + 64'(2 * CAL_SAMPLES) - 64'd1) / 64'(2 * CAL_SAMPLES);
  localparam int MW    = $clog2(RECIP_V + 64'd1);
  localparam int QW    = XW + MW;
  localparam int PW    = UB + pcoc_pkg::GAIN_W;
  localparam logic [MW-1:0] RECIP = MW'(RECIP_V);

  logic [SUM_W-1:0] sum_r, sum_nxt, sum_add;
  logic [XW-1:0]    num_r, num_nxt;
  logic [UB-1:0]    off_r, off_nxt;
  logic [QW-1:0]    quot;
  logic [UB-1:0]    s, diff;
  logic [PW-1:0]    prod;

  assign s       = sample[UB-1:0];
  assign sum_add = sum_r + SUM_W'(s);
  assign quot    = QW'(num_r) * QW'(RECIP);

  always_comb begin
    sum_nxt = sum_r;
    num_nxt = num_r;
    off_nxt = off_r;
    if (ctl.acc) begin
      sum_nxt = sum_add;
    end
    if (ctl.fin) begin
      // numerator 2*sum + N, divided by 2*N: mean rounded half up
      num_nxt = {sum_add, 1'b0} + XW'(CAL_SAMPLES);
    end
    if (ctl.step) begin
      off_nxt = quot[K +: UB];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r <= '0;
      num_r <= '0;
      off_r <= '0;
    end else begin
      sum_r <= sum_nxt;
      num_r <= num_nxt;
      off_r <= off_nxt;
    end
  end

  assign diff = s - off_r;
  assign prod = PW'(diff) * PW'(gain);

  always_comb begin
    if (ctl.done && (s > off_r)) begin
      current = pcoc_pkg::OUT_W'(prod);
    end else begin
      current = '0;
    end
  end

endmodule

// ----- rtl/core/pcoc_merge.sv -----
// ----------------------------------------------------------------------------
// pcoc_merge
// Gathers the lane currents into one word; output register with skid stage.
// ----------------------------------------------------------------------------
module pcoc_merge (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                up_valid,
  output logic                up_ready,
  input  pcoc_pkg::current_t  lane_cur [pcoc_pkg::PHASES],
  input  logic                calibrated,
  pcoc_out_if.source          dn
);

  pcoc_pkg::pcoc_word_t word, out_r, out_nxt, skid_r, skid_nxt;
  logic out_valid_r, out_valid_nxt, skid_valid_r, skid_valid_nxt;
  logic pop;

  always_comb begin
    word.current_u  = lane_cur[0];
    word.current_v  = lane_cur[1];
    word.current_w  = lane_cur[2];
    word.calibrated = calibrated;
  end

  assign up_ready = !skid_valid_r;
  assign pop      = out_valid_r && dn.ready;

  always_comb begin
    out_nxt        = out_r;
    skid_nxt       = skid_r;
    out_valid_nxt  = out_valid_r;
    skid_valid_nxt = skid_valid_r;
    if (skid_valid_r) begin
      if (pop) begin
        out_nxt        = skid_r;
        skid_valid_nxt = 1'b0;
      end
    end else if (up_valid) begin
      if (!out_valid_r || pop) begin
        out_nxt       = word;
        out_valid_nxt = 1'b1;
      end else begin
        skid_nxt       = word;
        skid_valid_nxt = 1'b1;
      end
    end else if (pop) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r  <= out_nxt;
    skid_r <= skid_nxt;
  end

  assign dn.valid      = out_valid_r;
  assign dn.current_u  = out_r.current_u;
  assign dn.current_v  = out_r.current_v;
  assign dn.current_w  = out_r.current_w;
  assign dn.calibrated = out_r.calibrated;

endmodule

// ----- tb/tb_phase_current_offset_calibrator.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_phase_current_offset_calibrator
// Self-checking bench for the phase current offset calibrator.
// ----------------------------------------------------------------------------
// Runs the calibration pass (with the final word shaped to hit the rounding
// boundaries), then directed and random sample words under several gain
// settings. A scoreboard predicts offsets and scaled currents and checks
// every result word in order. Sender and receiver idle at random; one long
// receiver hold-off fills the block.
// ----------------------------------------------------------------------------

class current_scoreboard;
  localparam int CAL_WORDS = 100;

  bit                      done;
  bit [6:0]                count;
  bit [18:0]               sums[3];
  pcoc_pkg::sample_t       offsets[3];
  pcoc_pkg::gain_t         gain;
  pcoc_pkg::pcoc_word_t    expected_q[$];
  int                      mismatches;

  function pcoc_pkg::current_t scale(pcoc_pkg::sample_t s, pcoc_pkg::sample_t off);
    logic [39:0] prod;
    if (s <= off) return '0;
    prod = {28'd0, s - off} * {16'd0, gain};
    return (prod > 40'h0F_FFFF_FFFF) ? '1 : prod[35:0];
  endfunction

  function void note_samples(pcoc_pkg::sample_t u, pcoc_pkg::sample_t v,
                             pcoc_pkg::sample_t w);
    pcoc_pkg::sample_t    s[3];
    pcoc_pkg::pcoc_word_t exp_word;
    int unsigned          mean;
    s[0] = u;
    s[1] = v;
    s[2] = w;
    exp_word = '0;
    if (!done) begin
      for (int p = 0; p < 3; p++) sums[p] += s[p];
      count++;
      if (count >= CAL_WORDS) begin
        for (int p = 0; p < 3; p++) begin
          mean = (2 * sums[p] + CAL_WORDS) / (2 * CAL_WORDS);
          offsets[p] = mean[11:0];
        end
        done = 1'b1;
      end
    end else begin
      exp_word.current_u = scale(s[0], offsets[0]);
      exp_word.current_v = scale(s[1], offsets[1]);
      exp_word.current_w = scale(s[2], offsets[2]);
    end
    exp_word.calibrated = done;
    expected_q.push_back(exp_word);
  endfunction

  task report(string msg);
    $display("[%0t] MISMATCH %s", $time, msg);
    mismatches++;
  endtask

  task check_word(pcoc_pkg::current_t cu, pcoc_pkg::current_t cv,
                  pcoc_pkg::current_t cw, logic cal);
    pcoc_pkg::pcoc_word_t exp_word;
    if (expected_q.size() == 0) begin
      report("result word with none outstanding");
      return;
    end
    exp_word = expected_q.pop_front();
    if (cu !== exp_word.current_u)
      report($sformatf("current_u got %0d exp %0d", cu, exp_word.current_u));
    if (cv !== exp_word.current_v)
      report($sformatf("current_v got %0d exp %0d", cv, exp_word.current_v));
    if (cw !== exp_word.current_w)
      report($sformatf("current_w got %0d exp %0d", cw, exp_word.current_w));
    if (cal !== exp_word.calibrated)
      report($sformatf("calibrated got %0b exp %0b", cal, exp_word.calibrated));
  endtask
endclass

module tb_phase_current_offset_calibrator;

  localparam int CAL_WORDS   = 100;
  localparam int HOLD_CYCLES = 60;

  logic            clk = 1'b0;
  logic            rst_n;
  logic            cfg_we;
  pcoc_pkg::gain_t cfg_wdata;
  logic            hold_on;

  int src_idle;
  int snk_idle;

  event hold_go;

  current_scoreboard sb = new;

  pcoc_in_if  in_ch ();
  pcoc_out_if out_ch ();

  phase_current_offset_calibrator i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // long receiver hold-off, counted in cycles
  initial begin
    hold_on = 1'b0;
    @(hold_go);
    hold_on <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_on <= 1'b0;
  end

  // receiver: check, then choose ready for the next edge
  always @(posedge clk) begin
    if (out_ch.valid && out_ch.ready)
      sb.check_word(out_ch.current_u, out_ch.current_v, out_ch.current_w, out_ch.calibrated);
    if (!rst_n || hold_on) begin
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(0, 99) >= snk_idle);
    end
  end

  task automatic send_samples(input pcoc_pkg::sample_t u, input pcoc_pkg::sample_t v,
                              input pcoc_pkg::sample_t w);
    while ($urandom_range(0, 99) < src_idle) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid    <= 1'b1;
    in_ch.sample_u <= u;
    in_ch.sample_v <= v;
    in_ch.sample_w <= w;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_samples(u, v, w);
  endtask

  task automatic write_gain(input pcoc_pkg::gain_t g);
    cfg_we    <= 1'b1;
    cfg_wdata <= g;
    @(posedge clk);
    cfg_we    <= 1'b0;
    sb.gain = g;
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (25) @(posedge clk);
  endtask

  function automatic pcoc_pkg::sample_t jitter(input int centre);
    int v;
    v = centre + int'($urandom_range(0, 64)) - 32;
    if (v < 0) v = 0;
    if (v > 4095) v = 4095;
    return pcoc_pkg::sample_t'(v);
  endfunction

  function automatic pcoc_pkg::sample_t pick_sample(input pcoc_pkg::sample_t off);
    case ($urandom_range(0, 3))
      1: return pcoc_pkg::sample_t'(int'(jitter(int'(off))) / 8 + int'(off) - int'(off) / 8);
      2: return $urandom_range(0, 1) ? 12'hFFF : 12'h000;
      default: return pcoc_pkg::sample_t'($urandom_range(0, 4095));
    endcase
  endfunction

  function automatic pcoc_pkg::sample_t near_offset(input pcoc_pkg::sample_t off);
    int v;
    v = int'(off) + int'($urandom_range(0, 6)) - 3;
    if (v < 0) v = 0;
    if (v > 4095) v = 4095;
    return pcoc_pkg::sample_t'(v);
  endfunction

  // U settles near zero, V near full scale; the last word puts the V and W
  // sums just below and exactly on a half-count rounding boundary
  task automatic calibrate();
    int c_v;
    int c_w;
    int r_v;
    int r_w;
    c_v = 4095 - int'($urandom_range(0, 60));
    c_w = int'($urandom_range(100, 3800));
    send_samples(12'h000, 12'hFFF, 12'h000);
    send_samples(12'h000, 12'hFFF, 12'hFFF);
    repeat (CAL_WORDS - 3)
      send_samples(($urandom_range(0, 9) == 0) ? 12'h001 : 12'h000, jitter(c_v), jitter(c_w));
    r_v = (49 + 500000 - int'(sb.sums[1])) % 100;
    r_w = (50 + 500000 - int'(sb.sums[2])) % 100;
    send_samples(12'h000, pcoc_pkg::sample_t'(3900 + r_v),
                 pcoc_pkg::sample_t'((c_w / 100) * 100 + r_w));
  endtask

  task automatic send_random(input int n);
    repeat (n) begin
      if ($urandom_range(0, 1))
        send_samples(near_offset(sb.offsets[0]), near_offset(sb.offsets[1]),
                     near_offset(sb.offsets[2]));
      else
        send_samples(pick_sample(sb.offsets[0]), pick_sample(sb.offsets[1]),
                     pick_sample(sb.offsets[2]));
    end
  endtask

  initial begin
    in_ch.valid    = 1'b0;
    in_ch.sample_u = '0;
    in_ch.sample_v = '0;
    in_ch.sample_w = '0;
    cfg_we         = 1'b0;
    cfg_wdata      = '0;
    rst_n          = 1'b0;
    src_idle       = 22;
    snk_idle       = 52;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    write_gain(pcoc_pkg::gain_t'($urandom_range(0, 24'hFFFFFF)));
    calibrate();
    send_samples(sb.offsets[0], sb.offsets[1], sb.offsets[2]);
    send_samples(sb.offsets[0] + 12'd1, sb.offsets[1] + 12'd1, sb.offsets[2] + 12'd1);
    send_samples(sb.offsets[0] - 12'd1, sb.offsets[1] - 12'd1, sb.offsets[2] - 12'd1);
    send_samples(12'h000, 12'h000, 12'h000);
    send_samples(12'hFFF, 12'hFFF, 12'hFFF);
    send_samples(12'hFFF, 12'h000, sb.offsets[2] + 12'd1);
    send_samples(12'h555, 12'hAAA, 12'h555);
    send_samples(12'hAAA, 12'h555, 12'hAAA);
    send_random(200);
    drain();

    write_gain(24'hFFFFFF);
    send_samples(12'hFFF, 12'hFFF, 12'hFFF);
    send_samples(12'h000, 12'h000, 12'h000);
    -> hold_go;
    send_random(150);
    drain();

    src_idle = 52;
    snk_idle = 22;
    write_gain(24'h000000);
    send_random(100);
    drain();
    write_gain(24'h000001);
    send_random(100);
    drain();

    src_idle = 0;
    snk_idle = 0;
    write_gain(pcoc_pkg::gain_t'($urandom_range(0, 24'hFFFFFF)));
    send_random(150);
    drain();

    if (sb.mismatches == 0 && sb.expected_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule

// ----- files.f -----
rtl/core/pcoc_pkg.sv
rtl/core/pcoc_if.sv
rtl/core/pcoc_ctrl.sv
rtl/core/pcoc_lane.sv
rtl/core/pcoc_merge.sv
rtl/core/phase_current_offset_calibrator.sv
tb/tb_phase_current_offset_calibrator.sv
